// File: rtl/pnf_pkg.sv
// Shared constants, coefficient tables and defaults for the pink noise filter.
package pnf_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int STATE_WIDTH_DEF  = 32;

  localparam int STAGES    = 6;
  localparam int COEF_FRAC = 22;
  localparam int COEF_W    = 24;
  localparam int DIGIT_W   = 4;
  localparam int AMP_W     = 15;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd9830;

  localparam logic REG_AMPLITUDE = 1'b0;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t POLE_TAB [STAGES] = '{
    24'sd4189522, 24'sd4166286, 24'sd4064281,
    24'sd3634364, 24'sd2306867, -24'sd3194382
  };

  // Input gains of the six integrators, then the direct white term.
  localparam coef_t GAIN_TAB [STAGES+1] = '{
    24'sd232859, 24'sd314891, 24'sd645302,
    24'sd1302271, 24'sd2235364, -24'sd70875,
    24'sd2248986
  };

endpackage

// File: rtl/pnf_digit_mul.sv
// Digit-serial signed multiplier: one coefficient digit per cycle, MSB first.
module pnf_digit_mul #(
  parameter int X_W = 35,
  parameter int P_W = 59
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [X_W-1:0]            x,
  input  logic signed [pnf_pkg::COEF_W-1:0] coef,
  output logic                             done,
  output logic signed [P_W-1:0]            product
);
  import pnf_pkg::*;

  localparam int DIGITS = COEF_W / DIGIT_W;
  localparam int CNT_W  = $clog2(DIGITS);

  logic signed [X_W-1:0]       x_hold;
  logic [COEF_W-1:0]           coef_sr;
  logic [CNT_W-1:0]            count;
  logic                        busy;
  logic [DIGIT_W-1:0]          digit;
  logic signed [DIGIT_W:0]     digit_ext;
  logic signed [X_W+DIGIT_W:0] partial;
  logic signed [P_W-1:0]       product_next;

  always_comb begin
    digit = coef_sr[COEF_W-1 -: DIGIT_W];
    // The leading digit carries the sign of the coefficient.
    if (count == '0) begin
      digit_ext = {digit[DIGIT_W-1], digit};
    end else begin
      digit_ext = {1'b0, digit};
    end
    partial      = x_hold * digit_ext;
    product_next = (product <<< DIGIT_W) + P_W'(partial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == CNT_W'(DIGITS - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == CNT_W'(DIGITS - 1)) begin
          busy  <= 1'b0;
          count <= '0;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_hold  <= x;
      coef_sr <= coef;
      product <= '0;
    end else if (busy) begin
      coef_sr <= coef_sr << DIGIT_W;
      product <= product_next;
    end
  end

endmodule

// File: rtl/pink_noise_filter.sv
// Pink noise filter top level: sequencer, integrator states, register port.
// The input is stalled until the previous sample is finished and handed to the output,
//   since the shared digit-serial multiplier computes all 14 products in turn
//   (each coefficient taken as 6 four-bit digits).
// Reset (rst, synchronous, active high): integrators cleared, amplitude 9830,
//   sequencer idle, no output pending.
module pink_noise_filter #(
  parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = pnf_pkg::STATE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] white_sample,
  input  logic                           start_of_clip,
  // sample output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] pink_sample,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pnf_pkg::*;

  // Number formats. States hold STATE_WIDTH-7 fraction bits (range +-64).
  localparam int STATE_FRAC = STATE_WIDTH - 7;
  localparam int WSHIFT     = STATE_FRAC - (SAMPLE_WIDTH - 1);
  localparam int IN_SHIFT   = (COEF_FRAC - WSHIFT > 0) ? (COEF_FRAC - WSHIFT) : 0;
  localparam int OUT_SHIFT  = STATE_FRAC + AMP_W - (SAMPLE_WIDTH - 1);
  localparam int SUM_W      = STATE_WIDTH + 3;
  localparam int P_W        = SUM_W + COEF_W;
  localparam int IDX_W      = $clog2(STAGES + 1);

  // Half an LSB of each rounded result, in product units.
  localparam logic [P_W-1:0] BIAS_FB  = (P_W'(1) << COEF_FRAC) >> 1;
  localparam logic [P_W-1:0] BIAS_IN  = (P_W'(1) << IN_SHIFT) >> 1;
  localparam logic [P_W-1:0] BIAS_OUT = (P_W'(1) << OUT_SHIFT) >> 1;

  localparam logic signed [STATE_WIDTH+1:0] STATE_HI = {3'b000, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH+1:0] STATE_LO = {3'b111, {(STATE_WIDTH-1){1'b0}}};
  localparam logic signed [P_W-1:0] OUT_HI =
    {{(P_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [P_W-1:0] OUT_LO =
    {{(P_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-2){1'b0}}, 1'b1};

  // Sequencer codes: each product has an issue step and a wait step.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FB    = 3'd1;
  localparam logic [2:0] S_FB_W  = 3'd2;
  localparam logic [2:0] S_IN    = 3'd3;
  localparam logic [2:0] S_IN_W  = 3'd4;
  localparam logic [2:0] S_AMP   = 3'd5;
  localparam logic [2:0] S_AMP_W = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                     state;
  logic [IDX_W-1:0]               idx;
  logic [AMP_W-1:0]               amplitude;
  logic signed [STATE_WIDTH-1:0]  integ [STAGES];
  logic signed [SAMPLE_WIDTH-1:0] white_hold;
  logic signed [SUM_W-1:0]        sum;
  logic signed [STATE_WIDTH:0]    fb;
  logic signed [SAMPLE_WIDTH-1:0] result;

  logic                           mul_start;
  logic                           mul_done;
  logic signed [SUM_W-1:0]        mul_x;
  coef_t                          mul_coef;
  logic signed [P_W-1:0]          product;

  logic signed [P_W-1:0]          rnd_fb;
  logic signed [P_W-1:0]          rnd_in;
  logic signed [P_W-1:0]          rnd_out;
  logic signed [STATE_WIDTH:0]    in_term;
  logic signed [STATE_WIDTH+1:0]  state_pre;
  logic signed [STATE_WIDTH-1:0]  state_new;
  logic signed [SAMPLE_WIDTH-1:0] out_sat;

  logic in_xfer;
  logic cfg_write;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_AMPLITUDE) ? 32'(amplitude) : 32'd0;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_coef  = '0;
    unique case (state)
      S_FB: begin
        mul_start = 1'b1;
        mul_x     = SUM_W'(integ[idx]);
        mul_coef  = POLE_TAB[idx];
      end
      S_IN: begin
        // index STAGES selects the direct white gain
        mul_start = 1'b1;
        mul_x     = SUM_W'(white_hold);
        mul_coef  = GAIN_TAB[idx];
      end
      S_AMP: begin
        mul_start = 1'b1;
        mul_x     = sum;
        mul_coef  = $signed(COEF_W'(amplitude));
      end
      S_IDLE, S_FB_W, S_IN_W, S_AMP_W, S_OUT: begin
        mul_start = 1'b0;
      end
    endcase
  end

  pnf_digit_mul #(
    .X_W (SUM_W),
    .P_W (P_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .coef    (mul_coef),
    .done    (mul_done),
    .product (product)
  );

  // Round half up: add half an LSB, then arithmetic shift (floor).
  always_comb begin
    rnd_fb    = (product + $signed(BIAS_FB)) >>> COEF_FRAC;
    rnd_in    = (product + $signed(BIAS_IN)) >>> IN_SHIFT;
    rnd_out   = (product + $signed(BIAS_OUT)) >>> OUT_SHIFT;
    in_term   = rnd_in[STATE_WIDTH:0];
    state_pre = (STATE_WIDTH+2)'(fb) + (STATE_WIDTH+2)'(in_term);
    if (state_pre > STATE_HI) begin
      state_new = STATE_HI[STATE_WIDTH-1:0];
    end else if (state_pre < STATE_LO) begin
      state_new = STATE_LO[STATE_WIDTH-1:0];
    end else begin
      state_new = state_pre[STATE_WIDTH-1:0];
    end
    // clamp symmetrically, so the most negative code never appears
    if (rnd_out > OUT_HI) begin
      out_sat = OUT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd_out < OUT_LO) begin
      out_sat = OUT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      out_sat = rnd_out[SAMPLE_WIDTH-1:0];
    end
  end

  // Control, integrator states and the amplitude register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
      amplitude <= AMP_RESET;
      for (int k = 0; k < STAGES; k++) begin
        integ[k] <= '0;
      end
    end else begin
      if (cfg_write && (paddr[2] == REG_AMPLITUDE)) begin
        amplitude <= pwdata[AMP_W-1:0];
      end
      // raise the output when a result is loaded, drop it once its transfer completes
      if ((state == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            idx   <= '0;
            state <= S_FB;
            // a new clip starts from silent integrators
            if (start_of_clip) begin
              for (int k = 0; k < STAGES; k++) begin
                integ[k] <= '0;
              end
            end
          end
        end
        S_FB: begin
          state <= S_FB_W;
        end
        S_FB_W: begin
          if (mul_done) begin
            state <= S_IN;
          end
        end
        S_IN: begin
          state <= S_IN_W;
        end
        S_IN_W: begin
          if (mul_done) begin
            if (idx == IDX_W'(STAGES)) begin
              state <= S_AMP;
            end else begin
              integ[idx[IDX_W-1:0]] <= state_new;
              idx                   <= idx + IDX_W'(1);
              // after the last integrator comes the direct term, no feedback
              state <= (idx == IDX_W'(STAGES - 1)) ? S_IN : S_FB;
            end
          end
        end
        S_AMP: begin
          state <= S_AMP_W;
        end
        S_AMP_W: begin
          if (mul_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      white_hold <= white_sample;
      sum        <= '0;
    end
    if ((state == S_FB_W) && mul_done) begin
      fb <= rnd_fb[STATE_WIDTH:0];
    end
    if ((state == S_IN_W) && mul_done) begin
      if (idx == IDX_W'(STAGES)) begin
        sum <= sum + SUM_W'(in_term);
      end else begin
        sum <= sum + SUM_W'(state_new);
      end
    end
    if ((state == S_AMP_W) && mul_done) begin
      result <= out_sat;
    end
    if ((state == S_OUT) && (!out_valid || !out_stall)) begin
      pink_sample <= result;
    end
  end

endmodule
